[src/pbl_pkg.sv]
// Shared types and constants for the page buffer LRU manager.
`timescale 1ns / 1ps

package pbl_pkg;

   typedef enum logic [2:0] {
      KIND_LOOKUP     = 3'd0,
      KIND_TOUCH      = 3'd1,
      KIND_UNPIN      = 3'd2,
      KIND_MARK_VALID = 3'd3,
      KIND_MARK_DIRTY = 3'd4,
      KIND_DROP_BLOCK = 3'd5,
      KIND_DROP_ALL   = 3'd6
   } kind_type;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NO_BUFFER = 2'd1;
   localparam logic [1:0] STAT_PINNED    = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] tablespace_id;
      logic [31:0] database_id;
      logic [31:0] relation_id;
      logic [1:0]  fork_req;
      logic [31:0] block_number;
      logic [5:0]  buffer_index;
   } req_type;

   typedef struct packed {
      logic [5:0]  slot;
      logic        found;
      logic [1:0]  status;
      logic        writeback;
      logic [31:0] wb_tablespace;
      logic [31:0] wb_database;
      logic [31:0] wb_relation;
      logic [1:0]  wb_fork;
      logic [31:0] wb_block;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_IDX,
      ST_SCAN,
      ST_ALLOC_WR,
      ST_WALK_CHK,
      ST_FIX_RD,
      ST_FIX_WR,
      ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CLEAR,
      DP_CAPTURE,
      DP_IDX_APPLY,
      DP_SCAN,
      DP_HIT_PIN,
      DP_DROP_PINNED,
      DP_DROP,
      DP_ALLOC_RD,
      DP_ALLOC_APPLY,
      DP_WALK_TAIL,
      DP_WALK_NEXT,
      DP_VICTIM,
      DP_FAIL,
      DP_FIX_RD,
      DP_FIX_WR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       clear_last;
      logic       scan_hit;
      logic       hit_pinned;
      logic       scan_done;
      logic       free_ok;
      logic       tail_ok;
      logic       walk_unpinned;
      logic       walk_prev_end;
      logic       fix_any;
   } stat_type;

endpackage

[src/pbl_ram.sv]
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module pbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[src/pbl_ctrl.sv]
// Controller state machine: sequences scans, list walks and link repairs.
`timescale 1ns / 1ps

module pbl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [2:0]        req_kind,
   input  pbl_pkg::stat_type stat,
   output pbl_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_valid
);

   pbl_pkg::state_type state_ff, state_in;
   logic               is_drop;

   assign is_drop = (stat.kind == pbl_pkg::KIND_DROP_BLOCK) ||
                    (stat.kind == pbl_pkg::KIND_DROP_ALL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbl_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pbl_pkg::ST_CLEAR: begin
            if (stat.clear_last) state_in = pbl_pkg::ST_IDLE;
         end
         pbl_pkg::ST_IDLE: begin
            if (start) begin
               case (req_kind) inside
                  pbl_pkg::KIND_LOOKUP, pbl_pkg::KIND_DROP_BLOCK, pbl_pkg::KIND_DROP_ALL:
                     state_in = pbl_pkg::ST_SCAN;
                  pbl_pkg::KIND_TOUCH, pbl_pkg::KIND_UNPIN, pbl_pkg::KIND_MARK_VALID,
                  pbl_pkg::KIND_MARK_DIRTY:
                     state_in = pbl_pkg::ST_IDX;
                  default:
                     state_in = pbl_pkg::ST_RESP;
               endcase
            end
         end
         pbl_pkg::ST_IDX: state_in = pbl_pkg::ST_FIX_RD;
         pbl_pkg::ST_SCAN: begin
            if (stat.scan_hit) begin
               if (stat.kind == pbl_pkg::KIND_LOOKUP || stat.hit_pinned)
                  state_in = pbl_pkg::ST_RESP;
               else
                  state_in = pbl_pkg::ST_FIX_RD;
            end else if (stat.scan_done) begin
               if (stat.kind != pbl_pkg::KIND_LOOKUP) state_in = pbl_pkg::ST_RESP;
               else if (stat.free_ok) state_in = pbl_pkg::ST_ALLOC_WR;
               else if (stat.tail_ok) state_in = pbl_pkg::ST_WALK_CHK;
               else state_in = pbl_pkg::ST_RESP;
            end
         end
         pbl_pkg::ST_ALLOC_WR: state_in = pbl_pkg::ST_RESP;
         pbl_pkg::ST_WALK_CHK: begin
            if (stat.walk_unpinned) state_in = pbl_pkg::ST_FIX_RD;
            else if (stat.walk_prev_end) state_in = pbl_pkg::ST_RESP;
         end
         pbl_pkg::ST_FIX_RD: begin
            if (stat.fix_any) state_in = pbl_pkg::ST_FIX_WR;
            else if (is_drop) state_in = pbl_pkg::ST_SCAN;
            else state_in = pbl_pkg::ST_RESP;
         end
         pbl_pkg::ST_FIX_WR: state_in = pbl_pkg::ST_FIX_RD;
         pbl_pkg::ST_RESP: state_in = pbl_pkg::ST_IDLE;
         default: state_in = pbl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = pbl_pkg::DP_NOP;
      unique case (state_ff)
         pbl_pkg::ST_CLEAR: cmd.op = pbl_pkg::DP_CLEAR;
         pbl_pkg::ST_IDLE: begin
            if (start) cmd.op = pbl_pkg::DP_CAPTURE;
         end
         pbl_pkg::ST_IDX: cmd.op = pbl_pkg::DP_IDX_APPLY;
         pbl_pkg::ST_SCAN: begin
            if (stat.scan_hit) begin
               if (stat.kind == pbl_pkg::KIND_LOOKUP) cmd.op = pbl_pkg::DP_HIT_PIN;
               else if (stat.hit_pinned) cmd.op = pbl_pkg::DP_DROP_PINNED;
               else cmd.op = pbl_pkg::DP_DROP;
            end else if (stat.scan_done) begin
               if (stat.kind != pbl_pkg::KIND_LOOKUP) cmd.op = pbl_pkg::DP_NOP;
               else if (stat.free_ok) cmd.op = pbl_pkg::DP_ALLOC_RD;
               else if (stat.tail_ok) cmd.op = pbl_pkg::DP_WALK_TAIL;
               else cmd.op = pbl_pkg::DP_FAIL;
            end else begin
               cmd.op = pbl_pkg::DP_SCAN;
            end
         end
         pbl_pkg::ST_ALLOC_WR: cmd.op = pbl_pkg::DP_ALLOC_APPLY;
         pbl_pkg::ST_WALK_CHK: begin
            if (stat.walk_unpinned) cmd.op = pbl_pkg::DP_VICTIM;
            else if (stat.walk_prev_end) cmd.op = pbl_pkg::DP_FAIL;
            else cmd.op = pbl_pkg::DP_WALK_NEXT;
         end
         pbl_pkg::ST_FIX_RD: begin
            if (stat.fix_any) cmd.op = pbl_pkg::DP_FIX_RD;
         end
         pbl_pkg::ST_FIX_WR: cmd.op = pbl_pkg::DP_FIX_WR;
         pbl_pkg::ST_RESP: cmd.op = pbl_pkg::DP_NOP;
         default: cmd.op = pbl_pkg::DP_NOP;
      endcase
   end

   assign busy      = (state_ff != pbl_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == pbl_pkg::ST_RESP);

`ifndef SYNTHESIS
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transaction accepted but block not busy");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block not idle after result");
`endif

endmodule

[src/pbl_dpath.sv]
// Datapath: entry RAM, list pointers, request and result registers.
`timescale 1ns / 1ps

module pbl_dpath #(
   parameter int NUM_BUFFERS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  pbl_pkg::req_type  req_data,
   input  pbl_pkg::cmd_type  cmd,
   output pbl_pkg::stat_type stat,
   output pbl_pkg::rsp_type  rsp_data
);

   localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int LW = $clog2(NUM_BUFFERS + 2);
   localparam logic [LW-1:0] LINK_END  = LW'(NUM_BUFFERS);
   localparam logic [LW-1:0] LINK_NONE = LW'(NUM_BUFFERS + 1);

   typedef struct packed {
      logic [31:0]   space;
      logic [31:0]   database;
      logic [31:0]   relation;
      logic [1:0]    fork_num;
      logic [31:0]   block;
      logic          tag_valid;
      logic          page_valid;
      logic          dirty;
      logic [15:0]   pin;
      logic [LW-1:0] next;
      logic [LW-1:0] prev;
      logic [LW-1:0] flink;
   } rec_type;

   localparam int RW = $bits(rec_type);

   pbl_pkg::req_type req_ff, req_in;
   pbl_pkg::rsp_type rsp_ff, rsp_in;
   logic [LW-1:0] head_ff, head_in, tail_ff, tail_in, fhead_ff, fhead_in;
   logic [LW-1:0] scan_ff, scan_in;
   logic [IW-1:0] chk_ff, chk_in, cur_ff, cur_in, clr_ff, clr_in;
   logic          pend_ff, pend_in;
   logic [2:0]    fix_pend_ff, fix_pend_in;
   logic [IW-1:0] fix_addr_ff [3];
   logic [IW-1:0] fix_addr_in [3];
   logic [LW-1:0] fix_val_ff [3];
   logic [LW-1:0] fix_val_in [3];

   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   rec_type       wr_rec, rec;
   logic [RW-1:0] rd_raw;

   pbl_ram #(.WIDTH(RW), .DEPTH(NUM_BUFFERS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rec = rec_type'(rd_raw);

   // tag compare against the captured transaction
   logic base_match, match;
   always_comb begin
      base_match = rec.tag_valid && rec.space == req_ff.tablespace_id &&
                   rec.database == req_ff.database_id &&
                   rec.relation == req_ff.relation_id;
      case (req_ff.kind)
         pbl_pkg::KIND_LOOKUP:
            match = base_match && rec.fork_num == req_ff.fork_req &&
                    rec.block == req_ff.block_number;
         pbl_pkg::KIND_DROP_BLOCK:
            match = base_match && rec.fork_num == req_ff.fork_req &&
                    rec.block >= req_ff.block_number;
         pbl_pkg::KIND_DROP_ALL: match = base_match;
         default: match = 1'b0;
      endcase
   end

   // unlink of the entry held in rec
   logic [LW-1:0] pv, nx, head_u, tail_u;
   logic          unl, fix_a, fix_b;
   assign pv     = rec.prev;
   assign nx     = rec.next;
   assign unl    = (pv != LINK_NONE);
   assign head_u = (unl && pv == LINK_END) ? nx : head_ff;
   assign tail_u = (unl && nx == LINK_END) ? pv : tail_ff;
   assign fix_a  = unl && (pv < LINK_END);
   assign fix_b  = unl && (nx < LINK_END);

   logic [15:0] pin_up;
   assign pin_up = (rec.pin == 16'hFFFF) ? rec.pin : rec.pin + 16'd1;

   rec_type alloc_rec;
   always_comb begin
      alloc_rec            = rec;
      alloc_rec.space      = req_ff.tablespace_id;
      alloc_rec.database   = req_ff.database_id;
      alloc_rec.relation   = req_ff.relation_id;
      alloc_rec.fork_num   = req_ff.fork_req;
      alloc_rec.block      = req_ff.block_number;
      alloc_rec.tag_valid  = 1'b1;
      alloc_rec.page_valid = 1'b0;
      alloc_rec.dirty      = 1'b0;
      alloc_rec.pin        = pin_up;
   end

   logic [1:0] fsel;
   always_comb begin
      if (fix_pend_ff[0]) fsel = 2'd0;
      else if (fix_pend_ff[1]) fsel = 2'd1;
      else fsel = 2'd2;
   end

   logic          idx_ok;
   logic [IW-1:0] idx_a;
   assign idx_ok = (32'(req_ff.buffer_index) < NUM_BUFFERS);
   assign idx_a  = IW'(req_ff.buffer_index);

   always_comb begin
      rec_type clr_rec;
      rec_type drop_rec;
      pbl_pkg::rsp_type wb_rsp;
      clr_rec       = '0;
      clr_rec.next  = LINK_NONE;
      clr_rec.prev  = LINK_NONE;
      clr_rec.flink = LW'(clr_ff) + LW'(1);
      drop_rec       = '0;
      drop_rec.pin   = rec.pin;
      drop_rec.next  = LINK_NONE;
      drop_rec.prev  = LINK_NONE;
      drop_rec.flink = fhead_ff;
      wb_rsp      = rsp_ff;
      wb_rsp.slot = 6'(cur_ff);
      if (rec.dirty) begin
         wb_rsp.writeback     = 1'b1;
         wb_rsp.wb_tablespace = rec.space;
         wb_rsp.wb_database   = rec.database;
         wb_rsp.wb_relation   = rec.relation;
         wb_rsp.wb_fork       = rec.fork_num;
         wb_rsp.wb_block      = rec.block;
      end

      req_in      = req_ff;
      rsp_in      = rsp_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      fhead_in    = fhead_ff;
      scan_in     = scan_ff;
      chk_in      = chk_ff;
      cur_in      = cur_ff;
      clr_in      = clr_ff;
      pend_in     = pend_ff;
      fix_pend_in = fix_pend_ff;
      fix_addr_in = fix_addr_ff;
      fix_val_in  = fix_val_ff;
      wr_en       = 1'b0;
      wr_addr     = chk_ff;
      wr_rec      = rec;
      rd_addr     = scan_ff[IW-1:0];

      unique case (cmd.op)
         pbl_pkg::DP_NOP: ;
         pbl_pkg::DP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_rec  = clr_rec;
            clr_in  = clr_ff + IW'(1);
         end
         pbl_pkg::DP_CAPTURE: begin
            req_in      = req_data;
            rsp_in      = '0;
            scan_in     = '0;
            pend_in     = 1'b0;
            fix_pend_in = '0;
            rd_addr     = IW'(req_data.buffer_index);
         end
         pbl_pkg::DP_IDX_APPLY: begin
            wr_addr = idx_a;
            case (req_ff.kind)
               pbl_pkg::KIND_TOUCH: begin
                  if (idx_ok && rec.tag_valid && head_ff != LW'(idx_a)) begin
                     wr_en          = 1'b1;
                     wr_rec.prev    = LINK_END;
                     wr_rec.next    = head_u;
                     fix_pend_in    = {head_u < LINK_END, fix_b, fix_a};
                     fix_addr_in[0] = pv[IW-1:0];
                     fix_val_in[0]  = nx;
                     fix_addr_in[1] = nx[IW-1:0];
                     fix_val_in[1]  = pv;
                     fix_addr_in[2] = head_u[IW-1:0];
                     fix_val_in[2]  = LW'(idx_a);
                     head_in        = LW'(idx_a);
                     tail_in        = (head_u < LINK_END) ? tail_u : LW'(idx_a);
                  end
               end
               pbl_pkg::KIND_UNPIN: begin
                  if (idx_ok && rec.pin != 16'd0) begin
                     wr_en      = 1'b1;
                     wr_rec.pin = rec.pin - 16'd1;
                  end
               end
               pbl_pkg::KIND_MARK_VALID: begin
                  if (idx_ok && rec.tag_valid) begin
                     wr_en             = 1'b1;
                     wr_rec.page_valid = 1'b1;
                  end
               end
               pbl_pkg::KIND_MARK_DIRTY: begin
                  if (idx_ok && rec.pin != 16'd0) begin
                     wr_en        = 1'b1;
                     wr_rec.dirty = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         pbl_pkg::DP_SCAN: begin
            if (scan_ff < LINK_END) begin
               scan_in = scan_ff + LW'(1);
               pend_in = 1'b1;
               chk_in  = scan_ff[IW-1:0];
            end else begin
               pend_in = 1'b0;
            end
         end
         pbl_pkg::DP_HIT_PIN: begin
            wr_en        = 1'b1;
            wr_rec.pin   = pin_up;
            rsp_in.slot  = 6'(chk_ff);
            rsp_in.found = rec.page_valid;
            pend_in      = 1'b0;
         end
         pbl_pkg::DP_DROP_PINNED: begin
            rsp_in.slot   = 6'(chk_ff);
            rsp_in.status = pbl_pkg::STAT_PINNED;
            pend_in       = 1'b0;
         end
         pbl_pkg::DP_DROP: begin
            wr_en          = 1'b1;
            wr_rec         = drop_rec;
            fhead_in       = LW'(chk_ff);
            head_in        = head_u;
            tail_in        = tail_u;
            fix_pend_in    = {1'b0, fix_b, fix_a};
            fix_addr_in[0] = pv[IW-1:0];
            fix_val_in[0]  = nx;
            fix_addr_in[1] = nx[IW-1:0];
            fix_val_in[1]  = pv;
            pend_in        = 1'b0;
         end
         pbl_pkg::DP_ALLOC_RD: begin
            rd_addr = fhead_ff[IW-1:0];
            cur_in  = fhead_ff[IW-1:0];
         end
         pbl_pkg::DP_ALLOC_APPLY: begin
            fhead_in     = rec.flink;
            wr_en        = 1'b1;
            wr_addr      = cur_ff;
            wr_rec       = alloc_rec;
            wr_rec.flink = LINK_NONE;
            rsp_in       = wb_rsp;
         end
         pbl_pkg::DP_WALK_TAIL: begin
            rd_addr = tail_ff[IW-1:0];
            cur_in  = tail_ff[IW-1:0];
         end
         pbl_pkg::DP_WALK_NEXT: begin
            rd_addr = rec.prev[IW-1:0];
            cur_in  = rec.prev[IW-1:0];
         end
         pbl_pkg::DP_VICTIM: begin
            wr_en          = 1'b1;
            wr_addr        = cur_ff;
            wr_rec         = alloc_rec;
            wr_rec.next    = LINK_NONE;
            wr_rec.prev    = LINK_NONE;
            head_in        = head_u;
            tail_in        = tail_u;
            fix_pend_in    = {1'b0, fix_b, fix_a};
            fix_addr_in[0] = pv[IW-1:0];
            fix_val_in[0]  = nx;
            fix_addr_in[1] = nx[IW-1:0];
            fix_val_in[1]  = pv;
            rsp_in         = wb_rsp;
         end
         pbl_pkg::DP_FAIL: begin
            rsp_in.status = pbl_pkg::STAT_NO_BUFFER;
         end
         pbl_pkg::DP_FIX_RD: begin
            rd_addr = fix_addr_ff[fsel];
         end
         pbl_pkg::DP_FIX_WR: begin
            wr_en   = 1'b1;
            wr_addr = fix_addr_ff[fsel];
            // slot 0 repairs a forward link, the others a backward link
            if (fsel == 2'd0) wr_rec.next = fix_val_ff[fsel];
            else wr_rec.prev = fix_val_ff[fsel];
            fix_pend_in[fsel] = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= LINK_END;
         tail_ff     <= LINK_END;
         fhead_ff    <= '0;
         clr_ff      <= '0;
         pend_ff     <= 1'b0;
         fix_pend_ff <= '0;
         scan_ff     <= '0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         fhead_ff    <= fhead_in;
         clr_ff      <= clr_in;
         pend_ff     <= pend_in;
         fix_pend_ff <= fix_pend_in;
         scan_ff     <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      chk_ff      <= chk_in;
      cur_ff      <= cur_in;
      fix_addr_ff <= fix_addr_in;
      fix_val_ff  <= fix_val_in;
   end

   always_comb begin
      stat.kind          = req_ff.kind;
      stat.clear_last    = (clr_ff == IW'(NUM_BUFFERS - 1));
      stat.scan_hit      = pend_ff && match;
      stat.hit_pinned    = (rec.pin != 16'd0);
      stat.scan_done     = !pend_ff && (scan_ff == LINK_END);
      stat.free_ok       = (fhead_ff < LINK_END);
      stat.tail_ok       = (tail_ff < LINK_END);
      stat.walk_unpinned = (rec.pin == 16'd0);
      stat.walk_prev_end = (rec.prev >= LINK_END);
      stat.fix_any       = |fix_pend_ff;
   end

   assign rsp_data = rsp_ff;

endmodule

[src/page_buffer_lru_manager_top.sv]
// Page buffer tag manager: free list, LRU list and pin counts over NUM_BUFFERS entries.
//
// Usage: drive req_data and raise start; the transaction is taken at an edge
// where start is high and busy is low. busy stays high until the single
// result has been shown: rsp_valid is high for exactly one cycle with
// rsp_data, and the receiver must take it then (it cannot stall).
// Steps from acceptance to the result cycle:
//   touch, unpin, mark valid, mark dirty: one entry read; touch adds up to 3 link repairs
//   lookup hit at entry i: a scan of entries 0 to i
//   lookup miss: a full scan, then the free list head, or a walk
//     from the LRU tail past pinned entries, then its link repairs;
//     the lookup fails when all entries on the LRU list are pinned
//   drops: a full scan, with an unlink and link repairs per dropped entry
// busy drops in the cycle after the result, and only then can the next
// transaction be taken.
// The entry table sits in one RAM with one read and one write port, so the scan
// and the walk read one entry at a time, and each link repair a read and a write.
// After reset the block clears the table, one entry per cycle, holding busy
// high until the last entry is cleared, so no transaction is taken before then.
`timescale 1ns / 1ps

module page_buffer_lru_manager_top #(
   parameter int NUM_BUFFERS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pbl_pkg::req_type req_data,
   output logic             rsp_valid,
   output pbl_pkg::rsp_type rsp_data
);

   pbl_pkg::cmd_type  cmd;
   pbl_pkg::stat_type stat;

   pbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_data.kind),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   pbl_dpath #(.NUM_BUFFERS(NUM_BUFFERS)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
